@@ src/path_lateral_error_segmenter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the path lateral error segmenter
// Concurrent property forms used by ples_controller.
// ----------------------------------------------------------------------------
`ifndef PATH_LATERAL_ERROR_SEGMENTER_CORE_DEFINES_SVH
`define PATH_LATERAL_ERROR_SEGMENTER_CORE_DEFINES_SVH

// Expression must never hold at a clock edge outside reset.
`define PLES_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("ples assertion failed: forbidden condition");

// Antecedent implies consequent in the same cycle.
`define PLES_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ples assertion failed: implication");

// Antecedent implies consequent in the next cycle.
`define PLES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ples assertion failed: next-cycle implication");

`endif

@@ src/ples_pkg.sv @@
// ----------------------------------------------------------------------------
// ples_pkg
// Types, constants and tables shared by the segmenter modules.
// ----------------------------------------------------------------------------
package ples_pkg;

  localparam int MAX_POINTS   = 65536;
  localparam int CORDIC_STEPS = 16;
  localparam int PIDX_W       = $clog2(MAX_POINTS);
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam logic signed [16:0] CORDIC_GAIN = 17'sd19898;

  localparam logic [1:0] CFG_LAT_TOL   = 2'd0;
  localparam logic [1:0] CFG_FRONT_OFF = 2'd1;
  localparam logic [1:0] CFG_REAR_OFF  = 2'd2;

  localparam logic [30:0]        LAT_TOL_RESET   = 31'd6554;
  localparam logic signed [31:0] FRONT_OFF_RESET = 32'sd262144;
  localparam logic signed [31:0] REAR_OFF_RESET  = -32'sd65536;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        heading;
    logic [31:0]        arc_length;
    logic               final_point;
  } ples_in_t;

  typedef struct packed {
    logic [15:0]        end_index;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [31:0]        start_station;
    logic [31:0]        end_station;
    logic signed [31:0] rear_x;
    logic signed [31:0] rear_y;
    logic signed [31:0] front_x;
    logic signed [31:0] front_y;
    logic               path_done;
  } ples_out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CORDIC, S_OFFMUL, S_LATSUM, S_LATMUL, S_SPLIT, S_REARMUL, S_FIN
  } ples_state_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic off_mul;
    logic lat_sum;
    logic rear_mul;
    logic lat_mul;
    logic commit;
    logic load;
    logic load_done;
    logic rearm;
  } ples_cmd_t;

  typedef struct packed {
    logic step_done;
    logic split;
    logic fin;
    logic out_busy;
  } ples_status_t;

  // Arctangent of 2^-k, 2^32 units per circle.
  function automatic logic [31:0] atan_angle(input logic [4:0] k);
    logic [31:0] a;
    unique case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

@@ src/ples_datapath.sv @@
// ----------------------------------------------------------------------------
// ples_datapath
// CORDIC, offset and lateral error arithmetic, path state and result register.
// ----------------------------------------------------------------------------
module ples_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  ples_pkg::ples_in_t   in_data,
  input  ples_pkg::ples_cmd_t  cmd,
  output ples_pkg::ples_status_t status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ples_pkg::ples_out_t  out_data
);

  logic [30:0]        lat_tol;
  logic signed [31:0] front_off;
  logic signed [31:0] rear_off;

  ples_pkg::ples_in_t cur;
  logic                          flip;
  logic [ples_pkg::STEP_W-1:0]   k;
  logic signed [16:0]            cx, cy;
  logic signed [33:0]            cz;
  logic signed [16:0]            uc, us;

  logic signed [48:0] fp_x, fp_y, rp_x, rp_y;
  logic signed [35:0] vx, vy;
  logic [31:0]        edge_x, edge_y;
  logic signed [52:0] lp_a, lp_b;

  logic                        started;
  logic [ples_pkg::PIDX_W-1:0] pcount;
  logic signed [31:0]          anchor_x, anchor_y;
  logic signed [16:0]          anchor_cos, anchor_sin;
  logic [31:0]                 anchor_station;
  logic signed [31:0]          prior_x, prior_y;
  logic [31:0]                 prior_station;
  logic [31:0]                 front_edge_x, front_edge_y;

  logic signed [33:0] z_init;
  logic               flip_init;
  logic signed [33:0] atan_k;
  logic signed [35:0] ex, ey;
  logic signed [53:0] lat_diff;
  logic signed [38:0] lat;
  logic [38:0]        mag;
  logic [ples_pkg::PIDX_W-1:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_tol   <= ples_pkg::LAT_TOL_RESET;
      front_off <= ples_pkg::FRONT_OFF_RESET;
      rear_off  <= ples_pkg::REAR_OFF_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ples_pkg::CFG_LAT_TOL:   lat_tol   <= cfg_data[30:0];
        ples_pkg::CFG_FRONT_OFF: front_off <= $signed(cfg_data);
        ples_pkg::CFG_REAR_OFF:  rear_off  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Fold left half plane headings by half a circle.
  always_comb begin
    logic signed [33:0] hz;
    hz = $signed({2'b00, in_data.heading, 16'h0000});
    flip_init = 1'b0;
    if (in_data.heading >= 16'd16384 && in_data.heading < 16'd49152) begin
      flip_init = 1'b1;
      z_init = hz - 34'sh080000000;
    end else if (in_data.heading >= 16'd49152) begin
      z_init = hz - 34'sh100000000;
    end else begin
      z_init = hz;
    end
  end

  assign atan_k = $signed({2'b00, ples_pkg::atan_angle(5'(k))});
  assign uc = flip ? -cx : cx;
  assign us = flip ? -cy : cy;

  assign ex = 36'(cur.point_x) + 36'($signed(fp_x[48:15]));
  assign ey = 36'(cur.point_y) + 36'($signed(fp_y[48:15]));

  assign lat_diff = 54'(lp_a) - 54'(lp_b);
  assign lat = $signed(lat_diff[53:15]);
  assign mag = lat[38] ? 39'(-lat) : 39'(lat);

  assign idx_next = (pcount == ples_pkg::PIDX_W'(ples_pkg::MAX_POINTS - 1)) ?
                    '0 : pcount + 1'b1;

  assign status.step_done = (k == ples_pkg::STEP_W'(ples_pkg::CORDIC_STEPS - 1));
  assign status.split     = started && (mag > {8'b0, lat_tol});
  assign status.fin       = cur.final_point;
  assign status.out_busy  = out_valid && out_stall;

  // Item capture and CORDIC micro-rotations.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur  <= in_data;
      flip <= flip_init;
      cz   <= z_init;
      cx   <= ples_pkg::CORDIC_GAIN;
      cy   <= '0;
      k    <= '0;
    end else if (cmd.step) begin
      k <= k + 1'b1;
      if (!cz[33]) begin
        cx <= cx - (cy >>> k);
        cy <= cy + (cx >>> k);
        cz <= cz - atan_k;
      end else begin
        cx <= cx + (cy >>> k);
        cy <= cy - (cx >>> k);
        cz <= cz + atan_k;
      end
    end
  end

  // Products and sums.
  always_ff @(posedge clk) begin
    if (cmd.off_mul) begin
      fp_x <= 49'(front_off) * 49'(uc);
      fp_y <= 49'(front_off) * 49'(us);
    end
    if (cmd.rear_mul) begin
      rp_x <= 49'(rear_off) * 49'(anchor_cos);
      rp_y <= 49'(rear_off) * 49'(anchor_sin);
    end
    if (cmd.lat_sum) begin
      vx     <= ex - 36'(anchor_x);
      vy     <= ey - 36'(anchor_y);
      edge_x <= ex[31:0];
      edge_y <= ey[31:0];
    end
    if (cmd.lat_mul) begin
      lp_a <= 53'(anchor_cos) * 53'(vy);
      lp_b <= 53'(anchor_sin) * 53'(vx);
    end
  end

  // Path state.
  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      pcount         <= '0;
      anchor_x       <= '0;
      anchor_y       <= '0;
      anchor_cos     <= '0;
      anchor_sin     <= '0;
      anchor_station <= '0;
      prior_x        <= '0;
      prior_y        <= '0;
      prior_station  <= '0;
      front_edge_x   <= '0;
      front_edge_y   <= '0;
    end else if (cmd.commit) begin
      if (!started || status.split) begin
        anchor_x       <= cur.point_x;
        anchor_y       <= cur.point_y;
        anchor_cos     <= uc;
        anchor_sin     <= us;
        anchor_station <= cur.arc_length;
      end
      started       <= 1'b1;
      pcount        <= started ? idx_next : '0;
      front_edge_x  <= edge_x;
      front_edge_y  <= edge_y;
      prior_x       <= cur.point_x;
      prior_y       <= cur.point_y;
      prior_station <= cur.arc_length;
    end else if (cmd.rearm) begin
      started <= 1'b0;
      pcount  <= '0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.end_index     <= 16'(pcount);
      out_data.start_x       <= anchor_x;
      out_data.start_y       <= anchor_y;
      out_data.end_x         <= prior_x;
      out_data.end_y         <= prior_y;
      out_data.start_station <= anchor_station;
      out_data.end_station   <= prior_station;
      out_data.rear_x        <= anchor_x + $signed(rp_x[46:15]);
      out_data.rear_y        <= anchor_y + $signed(rp_y[46:15]);
      out_data.front_x       <= $signed(front_edge_x);
      out_data.front_y       <= $signed(front_edge_y);
      out_data.path_done     <= cmd.load_done;
    end
  end

endmodule

@@ src/ples_controller.sv @@
// ----------------------------------------------------------------------------
// ples_controller
// Sequencer for one point: capture, rotate, multiply, decide, emit.
// ----------------------------------------------------------------------------
`include "path_lateral_error_segmenter_core_defines.svh"

module ples_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ples_pkg::ples_status_t status,
  output ples_pkg::ples_cmd_t    cmd
);

  ples_pkg::ples_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ples_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ples_pkg::S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ples_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ples_pkg::S_CORDIC;
        end
      end
      ples_pkg::S_CORDIC: begin
        cmd.step = 1'b1;
        if (status.step_done) state_next = ples_pkg::S_OFFMUL;
      end
      ples_pkg::S_OFFMUL: begin
        cmd.off_mul = 1'b1;
        state_next  = ples_pkg::S_LATSUM;
      end
      ples_pkg::S_LATSUM: begin
        cmd.lat_sum  = 1'b1;
        cmd.rear_mul = 1'b1;
        state_next   = ples_pkg::S_LATMUL;
      end
      ples_pkg::S_LATMUL: begin
        cmd.lat_mul = 1'b1;
        state_next  = ples_pkg::S_SPLIT;
      end
      ples_pkg::S_SPLIT: begin
        if (!(status.split && status.out_busy)) begin
          cmd.commit = 1'b1;
          cmd.load   = status.split;
          state_next = status.fin ? ples_pkg::S_REARMUL : ples_pkg::S_IDLE;
        end
      end
      ples_pkg::S_REARMUL: begin
        cmd.rear_mul = 1'b1;
        state_next   = ples_pkg::S_FIN;
      end
      ples_pkg::S_FIN: begin
        if (!status.out_busy) begin
          cmd.load      = 1'b1;
          cmd.load_done = 1'b1;
          cmd.rearm     = 1'b1;
          state_next    = ples_pkg::S_IDLE;
        end
      end
      default: state_next = ples_pkg::S_IDLE;
    endcase
  end

  `PLES_ASSERT_NEVER(a_no_overwrite, clk, rst, cmd.load && status.out_busy)
  `PLES_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)
  `PLES_ASSERT_IMPL(a_rearm_on_final, clk, rst, cmd.rearm, status.fin && cmd.load_done)

endmodule

@@ src/path_lateral_error_segmenter_core.sv @@
// Sequence: capture, the 16-step iterative CORDIC, offset multiply, lateral
// sum, lateral multiply and split decision; a final point adds the rear
// multiply and the closing emit. An emit waits while the output register
// is stalled. A new point is taken only once the last one is through.
// Reset (rst, synchronous): configuration registers return to their defaults,
// the path re-arms, no result pending.
// ----------------------------------------------------------------------------
// path_lateral_error_segmenter_core
// Splits a stream of path points into straight segments by lateral error.
// ----------------------------------------------------------------------------
module path_lateral_error_segmenter_core (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // point input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  ples_pkg::ples_in_t  in_data,
  // segment output channel
  output logic                out_valid,
  input  logic                out_stall,
  output ples_pkg::ples_out_t out_data
);

  // Command and status between the sequencer and the datapath.
  ples_pkg::ples_cmd_t    cmd;
  ples_pkg::ples_status_t status;

  // Sequencer: hold off new transactions while a point is in work; advance
  // through rotation, multiply and decision steps; hold an emit while the
  // result register still waits on its consumer.
  ples_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: configuration registers, CORDIC, lateral error arithmetic,
  // anchor and prior point state, and the output register that parts the
  // two channels so a new point may enter while a segment waits.
  ples_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Path lateral error segmenter testbench
// Feeds path points through the valid/stall input channel and checks every
// segment on the output channel against a cycle-free predictor of the
// anchor/split/close behavior, under random bursts, gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;

  logic      clk;
  logic      rst;
  logic      cfg_wr_en;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic      in_valid;
  logic      in_stall;
  ples_pkg::ples_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  ples_pkg::ples_out_t out_data;

  path_lateral_error_segmenter_core u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state: a private copy of the configuration and path state.
  logic [30:0]        tol_q;
  logic signed [31:0] front_off_q;
  logic signed [31:0] rear_off_q;
  logic               path_open;
  logic [15:0]        prev_index;
  logic signed [31:0] anc_x, anc_y, prv_x, prv_y;
  logic signed [16:0] anc_c, anc_s;
  logic [31:0]        anc_st, prv_st, edge_x, edge_y;

  ples_pkg::ples_in_t  point_queue[$];
  ples_pkg::ples_out_t segment_queue[$];
  int        fail_count;
  longint    cycle_count;
  int        hold_off;
  bit        long_hold_req;
  bit        in_taken = 0;

  // Arithmetic shift right with floor, on 64-bit signed.
  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  // Unit vector of a heading via rotation-mode CORDIC in Q1.15.
  task automatic heading_unit(input logic [15:0] h, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit     flip;
    x = 19898;
    y = 0;
    flip = 0;
    if (h >= 16384 && h < 49152) begin
      flip = 1;
      z = longint'(h) * 65536 - 64'sd2147483648;
    end else if (h >= 49152) begin
      z = longint'(h) * 65536 - 64'sd4294967296;
    end else begin
      z = longint'(h) * 65536;
    end
    for (int k = 0; k < ples_pkg::CORDIC_STEPS; k++) begin
      dx = floor_shr(y, k);
      dy = floor_shr(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ples_pkg::atan_angle(k[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(ples_pkg::atan_angle(k[4:0]));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic ples_pkg::ples_out_t make_segment(input logic [15:0] idx,
      input logic [31:0] ex, input logic [31:0] ey, input logic [31:0] es, input bit done);
    ples_pkg::ples_out_t r;
    r.end_index     = idx;
    r.start_x       = anc_x;
    r.start_y       = anc_y;
    r.end_x         = ex;
    r.end_y         = ey;
    r.start_station = anc_st;
    r.end_station   = es;
    r.rear_x        = 32'(longint'(anc_x) + floor_shr(longint'(rear_off_q) * anc_c, 15));
    r.rear_y        = 32'(longint'(anc_y) + floor_shr(longint'(rear_off_q) * anc_s, 15));
    r.front_x       = edge_x;
    r.front_y       = edge_y;
    r.path_done     = done;
    return r;
  endfunction

  // Advance the predictor by one accepted point; queue the segments it causes.
  task automatic predict_segments(input ples_pkg::ples_in_t p);
    longint c, s, offx, offy, vx, vy, lat, mag;
    heading_unit(p.heading, c, s);
    offx = floor_shr(longint'(front_off_q) * c, 15);
    offy = floor_shr(longint'(front_off_q) * s, 15);
    if (!path_open) begin
      path_open = 1;
      prev_index = 0;
      anc_x = p.point_x; anc_y = p.point_y;
      anc_c = 17'(c); anc_s = 17'(s);
      anc_st = p.arc_length;
    end else begin
      vx = longint'(p.point_x) + offx - longint'(anc_x);
      vy = longint'(p.point_y) + offy - longint'(anc_y);
      lat = floor_shr(longint'(anc_c) * vy - longint'(anc_s) * vx, 15);
      mag = lat < 0 ? -lat : lat;
      if (mag > longint'({1'b0, tol_q})) begin
        segment_queue = {segment_queue, make_segment(prev_index, prv_x, prv_y, prv_st, 0)};
        anc_x = p.point_x; anc_y = p.point_y;
        anc_c = 17'(c); anc_s = 17'(s);
        anc_st = p.arc_length;
      end
      prev_index = prev_index + 16'd1;  // wraps at MAX_POINTS = 65536
    end
    edge_x = 32'(longint'(p.point_x) + offx);
    edge_y = 32'(longint'(p.point_y) + offy);
    prv_x = p.point_x; prv_y = p.point_y; prv_st = p.arc_length;
    if (p.final_point) begin
      segment_queue = {segment_queue, make_segment(prev_index, p.point_x, p.point_y,
                                                   p.arc_length, 1)};
      path_open = 0;
      prev_index = 0;
    end
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Cycle limit: ~1300 items, plus stalls, many times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("path_lateral_error_segmenter_core verification failed");
      $finish;
    end
  end

  // Driver: bursts of random length with random gaps; hold payload while stalled.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (in_valid && !in_taken) begin
      // hold the offered transaction
    end else begin
      if (in_valid) begin
        // previous transaction accepted at the last rising edge
        void'(point_queue.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 0;
      end else if (point_queue.size() > 0) begin
        in_valid <= 1;
        in_data <= point_queue[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Predict on acceptance, at the rising edge.
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) predict_segments(in_data);
  end

  // Receiver stall pattern, with a long hold-off on request.
  int stall_mode = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else if (long_hold_req) begin
      long_hold_req = 0;
      hold_off = 600;
      out_stall <= 1;
    end else if (hold_off > 0) begin
      hold_off--;
      out_stall <= 1;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor: compare each accepted segment with the oldest expectation.
  always @(posedge clk) begin
    ples_pkg::ples_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (segment_queue.size() == 0) begin
        $display("%0t: unexpected segment %p", $time, out_data);
        fail_count++;
      end else begin
        want = segment_queue.pop_front();
        if (out_data !== want) begin
          $display("%0t: segment mismatch expected %p actual %p", $time, want, out_data);
          fail_count++;
        end
      end
    end
  end

  function automatic ples_pkg::ples_in_t rand_point(input bit fin);
    ples_pkg::ples_in_t p;
    p.point_x     = $urandom;
    p.point_y     = $urandom;
    p.heading     = 16'($urandom);
    p.arc_length  = $urandom;
    p.final_point = fin;
    return p;
  endfunction

  // Points along a gently curving path with random noise and occasional kinks.
  task automatic queue_path(input int len);
    ples_pkg::ples_in_t p;
    int x, y, s;
    int h;
    x = $urandom_range(0, 2000000) - 1000000;
    y = $urandom_range(0, 2000000) - 1000000;
    s = $urandom_range(0, 100000);
    h = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++) begin
      p.point_x = x; p.point_y = y; p.heading = h[15:0];
      p.arc_length = s; p.final_point = (i == len - 1);
      if ($urandom_range(0, 30) == 0) p = rand_point(p.final_point);
      point_queue = {point_queue, p};
      x += $urandom_range(0, 40000) - 20000;
      y += $urandom_range(0, 40000) - 20000;
      s += $urandom_range(0, 60000);
      h += ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8000) - 4000 :
           $urandom_range(0, 200) - 100;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    if (idx == ples_pkg::CFG_LAT_TOL) tol_q = val[30:0];
    else if (idx == ples_pkg::CFG_FRONT_OFF) front_off_q = val;
    else if (idx == ples_pkg::CFG_REAR_OFF) rear_off_q = val;
  endtask

  // Wait for the block to drain, plus its latency for items with no result.
  task automatic drain;
    while (point_queue.size() > 0 || in_valid || segment_queue.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    ples_pkg::ples_in_t p;
    rst = 1; cfg_wr_en = 0; cfg_index = ples_pkg::CFG_LAT_TOL; cfg_data = 0;
    in_valid = 0; in_data = '0; out_stall = 0;
    fail_count = 0; cycle_count = 0; hold_off = 0; long_hold_req = 0;
    tol_q = ples_pkg::LAT_TOL_RESET;
    front_off_q = ples_pkg::FRONT_OFF_RESET;
    rear_off_q = ples_pkg::REAR_OFF_RESET;
    path_open = 0; prev_index = 0;
    anc_x = 0; anc_y = 0; anc_c = 0; anc_s = 0; anc_st = 0;
    prv_x = 0; prv_y = 0; prv_st = 0; edge_x = 0; edge_y = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: single-point path, extremes and wrapping sums, split on final.
    point_queue = {point_queue, rand_point(1)};
    p = '0; p.point_x = 32'h7FFFFFFF; p.point_y = 32'h80000000;
    p.heading = 16'h0000; p.arc_length = 32'hFFFFFFFF; point_queue = {point_queue, p};
    for (int i = 0; i < 16; i++) begin
      p = rand_point(0); p.heading = 16'h1 << i; point_queue = {point_queue, p};
    end
    p = '0; p.point_x = 32'h80000000; p.point_y = 32'h7FFFFFFF;
    p.heading = 16'hFFFF; p.final_point = 1; point_queue = {point_queue, p};
    p = '0; p.heading = 16'h4000; point_queue = {point_queue, p};
    p = '0; p.point_y = 32'h00100000; p.heading = 16'hC000; p.final_point = 1;
    point_queue = {point_queue, p};
    drain();

    // Several register settings, extremes included; one out-of-range write.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(ples_pkg::CFG_LAT_TOL, 32'd0);
          write_reg(ples_pkg::CFG_FRONT_OFF, 32'h7FFFFFFF);
          write_reg(ples_pkg::CFG_REAR_OFF, 32'h80000000);
        end
        1: begin
          write_reg(ples_pkg::CFG_LAT_TOL, 32'hFFFFFFFF);
          write_reg(ples_pkg::CFG_FRONT_OFF, 32'h80000000);
          write_reg(ples_pkg::CFG_REAR_OFF, 32'h7FFFFFFF);
        end
        2: begin
          write_reg(ples_pkg::CFG_LAT_TOL, 32'd20000);
          write_reg(ples_pkg::CFG_FRONT_OFF, 32'd0);
          write_reg(2'd3, $urandom);
        end
        default: begin
          write_reg(ples_pkg::CFG_LAT_TOL, $urandom_range(0, 200000));
          write_reg(ples_pkg::CFG_FRONT_OFF, $urandom_range(0, 600000) - 300000);
          write_reg(ples_pkg::CFG_REAR_OFF, $urandom_range(0, 600000) - 300000);
        end
      endcase
      if (phase == 3) long_hold_req = 1;
      while (point_queue.size() < 200) begin
        if ($urandom_range(0, 7) == 0)
          point_queue = {point_queue, rand_point($urandom_range(0, 1))};
        else queue_path($urandom_range(1, 30));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("path_lateral_error_segmenter_core verification clean");
    end else begin
      $display("path_lateral_error_segmenter_core verification failed");
    end
    $finish;
  end

endmodule
